// ===== rtl/core/ufas_pkg.sv =====
// ----------------------------------------------------------------------------
// ufas_pkg: shared types and codes of the unpacked float arithmetic core
// Operation codes, internal op kinds, the control word and default widths.
// ----------------------------------------------------------------------------
package ufas_pkg;

  localparam int FRAC_WIDTH_DEF = 32;   // default working fraction width
  localparam int FRAC_PORT_W    = 32;   // fraction width on the ports
  localparam int IN_EXP_W       = 9;
  localparam int EXP_W          = 11;

  // func codes on the input channel
  localparam logic [1:0] FUNC_ADD = 2'd0;
  localparam logic [1:0] FUNC_SUB = 2'd1;
  localparam logic [1:0] FUNC_MUL = 2'd2;
  localparam logic [1:0] FUNC_DIV = 2'd3;

  // effective operation after sign classification
  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]              kind;
    logic                    neg;
    logic                    zero;
    logic signed [EXP_W-1:0] exp;
  } ufas_ctl_t;

  localparam int CTL_W = $bits(ufas_ctl_t);

endpackage

// ===== rtl/core/unpacked_float_add_sub_mul_div.sv =====
// ----------------------------------------------------------------------------
// unpacked_float_add_sub_mul_div: add, subtract, multiply, divide core
// Pipeline: four arithmetic stages, FRAC_WIDTH divide stages, output register;
// the queue entry is written at the accept edge itself.
// Throughput: one operation per cycle while the output is not stalled; every op
// runs the full pipeline, whose length is set by the one-bit-per-stage restoring divider.
// Reset: synchronous active-low rst_n clears queue and pipeline valid bits.
// ----------------------------------------------------------------------------
module unpacked_float_add_sub_mul_div #(
  parameter int FRAC_WIDTH = ufas_pkg::FRAC_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // a_neg, a_exp[9], a_frac[32], b_neg, b_exp[9], b_frac[32]
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // r_neg, r_exp[11], r_frac[32]
  output logic        out_tuser   // r_zero
);

  localparam int W    = FRAC_WIDTH;
  localparam int SH_W = $clog2(W + 1);
  localparam int QW   = ufas_pkg::CTL_W + 2 * W + SH_W;

  ufas_pkg::ufas_ctl_t f_ctl, q_ctl, r_ctl;
  logic [W-1:0]        f_big, f_sml, q_big, q_sml, r_frac;
  logic [SH_W-1:0]     f_shamt, q_shamt;
  logic [QW-1:0]       q_pop_data;
  logic                q_full, q_vld, q_pop, push;

  assign push      = in_tvalid && in_tready;
  assign in_tready = !q_full;

  ufas_front #(.FRAC_WIDTH(W)) u_front (
    .func   (in_tuser),
    .a_neg  (in_tdata[0]),
    .a_exp  (in_tdata[9:1]),
    .a_frac (in_tdata[10 +: W]),
    .b_neg  (in_tdata[42]),
    .b_exp  (in_tdata[51:43]),
    .b_frac (in_tdata[52 +: W]),
    .ctl    (f_ctl),
    .big    (f_big),
    .sml    (f_sml),
    .shamt  (f_shamt)
  );

  ufas_queue #(.WIDTH(QW), .DEPTH(2)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_ctl, f_big, f_sml, f_shamt}),
    .full      (q_full),
    .pop       (q_pop),
    .vld       (q_vld),
    .pop_data  (q_pop_data)
  );

  assign {q_ctl, q_big, q_sml, q_shamt} = q_pop_data;

  ufas_back #(.FRAC_WIDTH(W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_vld    (q_vld),
    .q_ctl    (q_ctl),
    .q_big    (q_big),
    .q_sml    (q_sml),
    .q_shamt  (q_shamt),
    .q_pop    (q_pop),
    .res_vld  (out_tvalid),
    .res_rdy  (out_tready),
    .res_ctl  (r_ctl),
    .res_frac (r_frac)
  );

  assign out_tdata = {4'b0, {(ufas_pkg::FRAC_PORT_W - W){1'b0}}, r_frac,
                      r_ctl.exp, r_ctl.neg};
  assign out_tuser = r_ctl.zero;

  // a cancelled result carries all-zero sign, exponent and fraction
  a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("zero result with nonzero payload");

  // result exponent stays within the reachable range
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[11:1]) >= -11'sd512) &&
                   ($signed(out_tdata[11:1]) <= 11'sd511))
    else $error("result exponent out of range");

  // queue only refuses input while the pipeline is blocked at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready) || $past(!in_tready) || $past(push))
    else $error("input stalled without output back-pressure");

endmodule

// ===== rtl/core/ufas_front.sv =====
// ----------------------------------------------------------------------------
// ufas_front: operand classification
// Decodes the operation, restores hidden bits, orders operands and sets up
// exponent, sign and alignment shift for the back end.
// ----------------------------------------------------------------------------
module ufas_front #(
  parameter int FRAC_WIDTH = ufas_pkg::FRAC_WIDTH_DEF,
  localparam int SH_W      = $clog2(FRAC_WIDTH + 1)
) (
  input  logic [1:0]                          func,
  input  logic                                a_neg,
  input  logic signed [ufas_pkg::IN_EXP_W-1:0] a_exp,
  input  logic [FRAC_WIDTH-1:0]               a_frac,
  input  logic                                b_neg,
  input  logic signed [ufas_pkg::IN_EXP_W-1:0] b_exp,
  input  logic [FRAC_WIDTH-1:0]               b_frac,
  output ufas_pkg::ufas_ctl_t                 ctl,
  output logic [FRAC_WIDTH-1:0]               big,
  output logic [FRAC_WIDTH-1:0]               sml,
  output logic [SH_W-1:0]                     shamt
);

  localparam int EW = ufas_pkg::EXP_W;

  logic [FRAC_WIDTH-1:0] x, y;
  logic                  ae_gt, ae_eq, af_gt, do_add, swap, lt;
  logic signed [EW-1:0]  ae_x, be_x;
  logic [9:0]            diff;

  assign x     = {1'b1, a_frac[FRAC_WIDTH-1:1]};
  assign y     = {1'b1, b_frac[FRAC_WIDTH-1:1]};
  assign ae_gt = a_exp > b_exp;
  assign ae_eq = a_exp == b_exp;
  assign af_gt = a_frac > b_frac;
  assign lt    = x < y;
  assign ae_x  = EW'(a_exp);
  assign be_x  = EW'(b_exp);

  always_comb begin
    do_add   = (func == ufas_pkg::FUNC_ADD) ? (a_neg == b_neg) : (a_neg != b_neg);
    swap     = do_add ? !ae_gt : !(ae_gt || (ae_eq && af_gt));
    diff     = '0;
    ctl      = '0;
    big      = x;
    sml      = y;
    shamt    = '0;
    unique case (func)
      ufas_pkg::FUNC_ADD, ufas_pkg::FUNC_SUB: begin
        ctl.kind = do_add ? ufas_pkg::KIND_ADD : ufas_pkg::KIND_SUB;
        ctl.neg  = a_neg ^ (!do_add & swap);
        ctl.exp  = swap ? be_x : ae_x;
        big      = swap ? y : x;
        sml      = swap ? x : y;
        diff     = swap ? 10'(be_x - ae_x) : 10'(ae_x - be_x);
        shamt    = (diff >= 10'(FRAC_WIDTH)) ? SH_W'(FRAC_WIDTH) : SH_W'(diff);
      end
      ufas_pkg::FUNC_MUL: begin
        ctl.kind = ufas_pkg::KIND_MUL;
        ctl.neg  = a_neg ^ b_neg;
        ctl.exp  = ae_x + be_x + EW'(1);
      end
      ufas_pkg::FUNC_DIV: begin
        // pre-shift the divisor so the quotient comes out normalized
        ctl.kind = ufas_pkg::KIND_DIV;
        ctl.neg  = a_neg ^ b_neg;
        ctl.exp  = ae_x - be_x - EW'(lt);
        sml      = lt ? (y >> 1) : y;
      end
    endcase
  end

endmodule

// ===== rtl/core/ufas_queue.sv =====
// ----------------------------------------------------------------------------
// ufas_queue: short register queue
// Decouples the classifying front end from the execution pipeline.
// ----------------------------------------------------------------------------
module ufas_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             vld,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign vld      = cnt_r != '0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/ufas_back.sv =====
// ----------------------------------------------------------------------------
// ufas_back: execution pipeline
// Align/multiply, add/subtract/normalize, leading-zero count, renormalize,
// then one quotient bit per stage; ends in an output register.
// ----------------------------------------------------------------------------
module ufas_back #(
  parameter int FRAC_WIDTH = ufas_pkg::FRAC_WIDTH_DEF,
  localparam int SH_W      = $clog2(FRAC_WIDTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_vld,
  input  ufas_pkg::ufas_ctl_t   q_ctl,
  input  logic [FRAC_WIDTH-1:0] q_big,
  input  logic [FRAC_WIDTH-1:0] q_sml,
  input  logic [SH_W-1:0]       q_shamt,
  output logic                  q_pop,
  output logic                  res_vld,
  input  logic                  res_rdy,
  output ufas_pkg::ufas_ctl_t   res_ctl,
  output logic [FRAC_WIDTH-1:0] res_frac
);

  localparam int W    = FRAC_WIDTH;
  localparam int LZ_W = $clog2(W);
  localparam int NST  = 4 + W;
  localparam int EW   = ufas_pkg::EXP_W;

  typedef struct packed {
    ufas_pkg::ufas_ctl_t ctl;
    logic [LZ_W-1:0]     lz;
    logic [W-1:0]        opa;
    logic [2*W-1:0]      acc;
  } stg_t;

  stg_t stg_r   [NST];
  stg_t stg_nxt [NST];
  logic vld_r   [NST];
  logic en;

  logic                  out_vld_r;
  ufas_pkg::ufas_ctl_t   out_ctl_r;
  logic [W-1:0]          out_frac_r;

  assign en       = !out_vld_r || res_rdy;
  assign q_pop    = q_vld && en;
  assign res_vld  = out_vld_r;
  assign res_ctl  = out_ctl_r;
  assign res_frac = out_frac_r;

  // align / multiply / first remainder step
  always_comb begin
    stg_nxt[0]     = '0;
    stg_nxt[0].ctl = q_ctl;
    stg_nxt[0].opa = (q_ctl.kind == ufas_pkg::KIND_DIV) ? q_sml : q_big;
    unique case (q_ctl.kind)
      ufas_pkg::KIND_ADD, ufas_pkg::KIND_SUB:
        stg_nxt[0].acc = {{W{1'b0}}, q_sml >> q_shamt};
      ufas_pkg::KIND_MUL:
        stg_nxt[0].acc = {{W{1'b0}}, q_big} * {{W{1'b0}}, q_sml};
      ufas_pkg::KIND_DIV:
        stg_nxt[0].acc = {{W{1'b0}}, (q_big >= q_sml) ? q_big - q_sml : q_big};
    endcase
  end

  // add / subtract / product normalize / second remainder step
  logic [W:0]   s2_sum;
  logic [W-1:0] s2_dif, s2_p, s2_r;
  always_comb begin
    stg_nxt[1] = stg_r[0];
    s2_sum = {1'b0, stg_r[0].opa} + {1'b0, stg_r[0].acc[W-1:0]};
    s2_dif = stg_r[0].opa - stg_r[0].acc[W-1:0];
    s2_p   = stg_r[0].acc[2*W-1:W];
    s2_r   = stg_r[0].acc[W-1:0];
    unique case (stg_r[0].ctl.kind)
      ufas_pkg::KIND_ADD: begin
        if (s2_sum[W]) begin
          stg_nxt[1].ctl.exp = stg_r[0].ctl.exp + EW'(1);
          stg_nxt[1].acc     = {{W{1'b0}}, s2_sum[W-1:1], 1'b0};
        end else begin
          stg_nxt[1].acc     = {{W{1'b0}}, s2_sum[W-2:0], 1'b0};
        end
      end
      ufas_pkg::KIND_SUB:
        stg_nxt[1].acc = {{W{1'b0}}, s2_dif};
      ufas_pkg::KIND_MUL: begin
        if (s2_p[W-1]) begin
          stg_nxt[1].acc = {{W{1'b0}}, s2_p[W-2:0], 1'b0};
        end else begin
          stg_nxt[1].ctl.exp = stg_r[0].ctl.exp - EW'(1);
          stg_nxt[1].acc     = {{W{1'b0}}, s2_p[W-3:0], 2'b00};
        end
      end
      ufas_pkg::KIND_DIV:
        stg_nxt[1].acc = {{W{1'b0}}, (s2_r >= stg_r[0].opa) ? s2_r - stg_r[0].opa : s2_r};
    endcase
  end

  // leading-zero count of the difference
  logic found;
  always_comb begin
    stg_nxt[2] = stg_r[1];
    found      = 1'b0;
    if (stg_r[1].ctl.kind == ufas_pkg::KIND_SUB) begin
      stg_nxt[2].lz       = '0;
      stg_nxt[2].ctl.zero = stg_r[1].acc[W-1:0] == '0;
      for (int i = W - 1; i >= 0; i--) begin
        if (!found && stg_r[1].acc[i]) begin
          stg_nxt[2].lz = LZ_W'(W - 1 - i);
          found         = 1'b1;
        end
      end
    end
  end

  // renormalize; exact cancellation gives an all-zero result
  logic [W-1:0] s4_sh;
  always_comb begin
    stg_nxt[3] = stg_r[2];
    s4_sh      = stg_r[2].acc[W-1:0] << stg_r[2].lz;
    if (stg_r[2].ctl.kind == ufas_pkg::KIND_SUB) begin
      if (stg_r[2].ctl.zero) begin
        stg_nxt[3].ctl.neg = 1'b0;
        stg_nxt[3].ctl.exp = '0;
        stg_nxt[3].acc     = '0;
      end else begin
        stg_nxt[3].ctl.exp = stg_r[2].ctl.exp - EW'(stg_r[2].lz);
        stg_nxt[3].acc     = {{W{1'b0}}, s4_sh[W-2:0], 1'b0};
      end
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0] t;
    logic       ge;
    always_comb begin
      stg_nxt[4+k] = stg_r[3+k];
      t  = {stg_r[3+k].acc[W-1:0], 1'b0};
      ge = t >= {1'b0, stg_r[3+k].opa};
      if (stg_r[3+k].ctl.kind == ufas_pkg::KIND_DIV) begin
        stg_nxt[4+k].acc = {stg_r[3+k].acc[2*W-2:W], ge,
                            ge ? W'(t - {1'b0, stg_r[3+k].opa}) : t[W-1:0]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        vld_r[i] <= 1'b0;
      end
      out_vld_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= q_vld;
      for (int i = 1; i < NST; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_vld_r <= vld_r[NST-1];
    end
  end

  // advance all stages together while the output register can take a result
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NST; i++) begin
        stg_r[i] <= stg_nxt[i];
      end
      out_ctl_r  <= stg_r[NST-1].ctl;
      out_frac_r <= (stg_r[NST-1].ctl.kind == ufas_pkg::KIND_DIV) ?
                    stg_r[NST-1].acc[2*W-1:W] : stg_r[NST-1].acc[W-1:0];
    end
  end

endmodule
